>>> sv/ohash_pkg.sv
// Shared types, codes and size tables of the open-addressing hash table.
`timescale 1ns / 1ps
`default_nettype none
package ohash_pkg;

	localparam int REC_W       = 64;
	localparam int LEN_W       = 4;
	localparam int KEY_W       = 32;
	localparam int STEP_W      = 4;
	localparam int PRIME_W     = 17;
	localparam int HYST_W      = 8;
	localparam int PRIME_COUNT = 12;

	localparam logic [PRIME_W-1:0] ADLER_MOD = 17'd65521;

	// Operation codes; any other code is a lookup
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;

	// Collision step codes; any other code is linear
	localparam logic [1:0] MODE_QUAD   = 2'd1;
	localparam logic [1:0] MODE_DOUBLE = 2'd2;

	// Result status codes
	localparam logic [2:0] STATUS_INSERTED = 3'd0;
	localparam logic [2:0] STATUS_PRESENT  = 3'd1;
	localparam logic [2:0] STATUS_DELETED  = 3'd2;
	localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
	localparam logic [2:0] STATUS_FOUND    = 3'd4;
	localparam logic [2:0] STATUS_CAP      = 3'd5;

	typedef logic [PRIME_W-1:0] prime_t;

	localparam prime_t PRIMES [PRIME_COUNT] = '{
		17'd5, 17'd23, 17'd127, 17'd251, 17'd509, 17'd1021,
		17'd2039, 17'd4093, 17'd8191, 17'd16381, 17'd32749, 17'd65521};
	localparam prime_t HALVES [PRIME_COUNT] = '{
		17'd2, 17'd11, 17'd63, 17'd125, 17'd254, 17'd510,
		17'd1019, 17'd2046, 17'd4095, 17'd8190, 17'd16374, 17'd32760};
	localparam prime_t TENTHS [PRIME_COUNT] = '{
		17'd0, 17'd2, 17'd12, 17'd25, 17'd50, 17'd102,
		17'd203, 17'd409, 17'd819, 17'd1638, 17'd3274, 17'd6552};

	typedef struct packed {
		logic [1:0]       func;
		logic [REC_W-1:0] rec_bytes;
		logic [LEN_W-1:0] rec_len;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [9:0]       slot;
		logic [KEY_W-1:0] key;
		logic [9:0]       occupied;
		logic [2:0]       size_step;
	} rsp_t;

	// One stored record
	typedef struct packed {
		logic [REC_W-1:0] rec;
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] hash;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_RB_CLR, ST_RB_RD, ST_RB_EV,
		ST_MOD_GO, ST_MOD, ST_P_RD, ST_P_EV, ST_DONE
	} state_t;

	typedef enum logic [1:0] {JOB_FIND, JOB_PLACE, JOB_MOVE} job_t;

	function automatic prime_t prime_at(input logic [STEP_W-1:0] s);
		return (s < STEP_W'(PRIME_COUNT)) ? PRIMES[s] : PRIMES[0];
	endfunction

	function automatic prime_t half_at(input logic [STEP_W-1:0] s);
		return (s < STEP_W'(PRIME_COUNT)) ? HALVES[s] : HALVES[0];
	endfunction

	function automatic prime_t tenth_at(input logic [STEP_W-1:0] s);
		return (s < STEP_W'(PRIME_COUNT)) ? TENTHS[s] : TENTHS[0];
	endfunction

endpackage
`default_nettype wire

>>> sv/open_addressing_hash_table.sv
// Top level of the open-addressing hash table with two-bank rebuild.
//
// Requests arrive on in_valid/in_ready with an insert, delete or lookup of
// a record of up to eight bytes; each request gives exactly one response on
// out_valid/out_ready. The probe mode is written on cfg_valid/cfg_ready
// (always ready); the user must write it only while the table is idle,
// which the block does not enforce. A request enters, is hashed byte by
// byte, has its key reduced by the table size, is probed (each probe is a
// flag and record memory read, then evaluate and write back) and posts its
// response. An insert that grows the table, or a delete that shrinks it,
// adds a rebuild: the other bank is cleared, each old slot is read and
// evaluated, and each moved record is reduced and probed. The single read
// port of the slot memories splits each probe into a read and an evaluate.
// After reset both banks of slot flags are cleared before the first
// request is taken. One request is worked at a time; a finished response
// waits until the output register is free or being emptied and then moves
// there, after which the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_table import ohash_pkg::*; #(
	parameter int MAX_SIZE_STEP = 5,
	parameter int BANK_DEPTH    = 1024,
	parameter int RECORD_BYTES  = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire req_t       in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output rsp_t            out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_data
);

	localparam int AW = $clog2(2 * BANK_DEPTH);
	localparam int SW = $clog2(BANK_DEPTH + 1);
	localparam int HQ = 2 * HYST_W;

	localparam logic [AW-1:0]      LAST_ADDR = AW'(2 * BANK_DEPTH - 1);
	localparam logic [AW-1:0]      LAST_BANK = AW'(BANK_DEPTH - 1);
	localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(RECORD_BYTES);
	localparam logic [STEP_W-1:0]  STEP_MAX  = STEP_W'(MAX_SIZE_STEP);
	localparam logic [PRIME_W-1:0] DEPTH_P   = PRIME_W'(BANK_DEPTH);

	// Slot memories: flags are {valid, tombstone, skipped}
	logic [2:0] flag_mem [2*BANK_DEPTH];
	entry_t     data_mem [2*BANK_DEPTH];
	logic [2:0] rd_flags_q;
	entry_t     rd_entry_q;

	state_t state_q, state_d;
	job_t   job_q;

	logic             grow_q;
	logic [1:0]       op_func_q;
	logic [REC_W-1:0] op_rec_q;
	logic [LEN_W-1:0] op_len_q;
	logic [KEY_W-1:0] op_key_q;
	entry_t           mv_q;
	logic [KEY_W-1:0] pkey_q;
	logic [STEP_W-1:0] tstep_q;
	logic             tbank_q;
	logic [SW-1:0]    idx_q;
	logic [SW-1:0]    f_q;
	logic [SW-1:0]    d_q;
	logic [SW-1:0]    s0_q;
	logic [SW-1:0]    h2_q;
	logic [SW-1:0]    pc_q;
	logic [STEP_W-1:0] rb_new_q;
	logic [SW-1:0]    rb_i_q;
	logic [AW-1:0]    clr_q;
	logic             bank_q;
	logic [STEP_W-1:0] step_q;
	logic [SW-1:0]    count_q;
	logic [HYST_W-1:0] hyst_q;
	logic [HQ-1:0]    hyst_sq_q;
	logic [1:0]       mode_q;
	logic [2:0]       res_status_q;
	logic [SW-1:0]    res_slot_q;
	logic             out_valid_q;
	rsp_t             out_q;

	// Memory port controls
	logic          fl_we;
	logic          dt_we;
	logic [AW-1:0] fl_waddr;
	logic [2:0]    fl_wdata;
	entry_t        dt_wdata;
	logic [AW-1:0] rd_addr;

	logic             adler_start;
	logic             adler_busy;
	logic [KEY_W-1:0] adler_key;
	logic             mod_start;
	logic             mod_busy;
	logic [SW-1:0]    rem_a;
	logic [SW-1:0]    rem_b;

	logic [LEN_W-1:0] len_c;
	logic [REC_W-1:0] rec_m;
	logic [SW-1:0]    t_size;
	logic [SW-1:0]    t_r;
	logic [SW-1:0]    old_size;
	logic [AW-1:0]    probe_addr;
	logic             fv, ft, fs;
	logic             match;
	logic             chain_end;
	logic             last_probe;
	logic             rb_last_src;
	logic             quad;
	logic             dbl;
	logic [SW:0]      sum_i;
	logic [SW:0]      sum_f;
	logic [SW:0]      sum_d;
	logic [SW-1:0]    idx_nx;
	logic [SW-1:0]    f_nx;
	logic [SW-1:0]    d_nx;
	logic [SW-1:0]    h2_new;
	logic             grow_need;
	logic             grow_ok;
	logic [SW-1:0]    cnt_dec;
	logic             shrink;
	logic             out_take;

	function automatic logic [AW-1:0] slot_addr(input logic bank, input logic [SW-1:0] idx);
		return bank ? AW'(BANK_DEPTH) + AW'(idx) : AW'(idx);
	endfunction

	// Start term and its increment of the cumulative probe step
	function automatic logic [SW-1:0] f_init(input logic dm, input logic [SW-1:0] h2);
		return dm ? h2 : SW'(1);
	endfunction

	function automatic logic [SW-1:0] d_init(input logic dm, input logic qm,
			input logic [SW-1:0] h2);
		return dm ? h2 : (qm ? SW'(3) : SW'(1));
	endfunction

	ohash_adler u_adler (
		.clk   (clk),
		.arst_n(arst_n),
		.start (adler_start),
		.rec   (rec_m),
		.len   (len_c),
		.busy  (adler_busy),
		.key   (adler_key)
	);

	ohash_mod #(.W(SW)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(pkey_q),
		.mod_a   (t_size),
		.mod_b   (t_r),
		.busy    (mod_busy),
		.rem_a   (rem_a),
		.rem_b   (rem_b)
	);

	// Clamp the length and drop bytes past it
	always_comb begin
		len_c = (in_data.rec_len > LEN_MAX) ? LEN_MAX : in_data.rec_len;
		for (int k = 0; k < 8; k++) begin
			rec_m[8*k +: 8] = (LEN_W'(k) < len_c) ? in_data.rec_bytes[8*k +: 8] : 8'h00;
		end
	end

	// Probe arithmetic and decisions
	always_comb begin
		t_size      = SW'(prime_at(tstep_q));
		t_r         = (tstep_q == '0) ? SW'(3) : SW'(prime_at(tstep_q - 1'b1));
		old_size    = SW'(prime_at(step_q));
		probe_addr  = slot_addr(tbank_q, idx_q);
		fv          = rd_flags_q[2];
		ft          = rd_flags_q[1];
		fs          = rd_flags_q[0];
		match       = fv && (rd_entry_q.len == op_len_q) && (rd_entry_q.rec == op_rec_q);
		chain_end   = !ft && !fs;
		last_probe  = (pc_q == t_size - 1'b1);
		rb_last_src = (rb_i_q == old_size - 1'b1);
		quad        = (mode_q == MODE_QUAD);
		dbl         = (mode_q == MODE_DOUBLE);
		sum_i       = {1'b0, idx_q} + {1'b0, f_q};
		idx_nx      = (sum_i >= {1'b0, t_size}) ? SW'(sum_i - {1'b0, t_size}) : SW'(sum_i);
		sum_f       = {1'b0, f_q} + {1'b0, d_q};
		f_nx        = (sum_f >= {1'b0, t_size}) ? SW'(sum_f - {1'b0, t_size}) : SW'(sum_f);
		sum_d       = {1'b0, d_q} + (SW + 1)'(2);
		d_nx        = !quad ? d_q :
			((sum_d >= {1'b0, t_size}) ? SW'(sum_d - {1'b0, t_size}) : SW'(sum_d));
		h2_new      = t_r - rem_b;
		grow_need   = PRIME_W'(count_q) > half_at(step_q);
		grow_ok     = (step_q < STEP_MAX) && (prime_at(step_q + 1'b1) <= DEPTH_P);
		cnt_dec     = (count_q != '0) ? count_q - 1'b1 : count_q;
		shrink      = (step_q != '0) &&
			((PRIME_W + 1)'(cnt_dec) <
			 ({1'b0, tenth_at(step_q)} + (PRIME_W + 1)'(hyst_sq_q)));
		out_take    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port controls
	always_comb begin
		state_d     = state_q;
		fl_we       = 1'b0;
		dt_we       = 1'b0;
		fl_waddr    = probe_addr;
		fl_wdata    = '0;
		dt_wdata    = (job_q == JOB_MOVE) ? mv_q : '{rec: op_rec_q, len: op_len_q, hash: op_key_q};
		rd_addr     = probe_addr;
		adler_start = 1'b0;
		mod_start   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				fl_we    = 1'b1;
				fl_waddr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					adler_start = 1'b1;
					state_d     = ST_HASH;
				end
			end
			ST_HASH: begin
				if (!adler_busy) begin
					if (op_func_q == FUNC_INSERT && grow_need) begin
						state_d = grow_ok ? ST_RB_CLR : ST_DONE;
					end else begin
						state_d = ST_MOD_GO;
					end
				end
			end
			ST_RB_CLR: begin
				fl_we    = 1'b1;
				fl_waddr = slot_addr(!bank_q, SW'(clr_q));
				if (clr_q == LAST_BANK) begin
					state_d = ST_RB_RD;
				end
			end
			ST_RB_RD: begin
				rd_addr = slot_addr(bank_q, rb_i_q);
				state_d = ST_RB_EV;
			end
			ST_RB_EV: begin
				if (fv) begin
					state_d = ST_MOD_GO;
				end else if (rb_last_src) begin
					state_d = grow_q ? ST_MOD_GO : ST_DONE;
				end else begin
					state_d = ST_RB_RD;
				end
			end
			ST_MOD_GO: begin
				mod_start = 1'b1;
				state_d   = ST_MOD;
			end
			ST_MOD: begin
				if (!mod_busy) begin
					state_d = ST_P_RD;
				end
			end
			ST_P_RD: begin
				state_d = ST_P_EV;
			end
			ST_P_EV: begin
				case (job_q)
					JOB_FIND: begin
						if (match) begin
							state_d = ST_DONE;
							if (op_func_q == FUNC_DELETE) begin
								fl_we    = 1'b1;
								fl_wdata = {1'b0, 1'b1, fs};
								if (shrink) begin
									state_d = ST_RB_CLR;
								end
							end
						end else if (chain_end || last_probe) begin
							state_d = (op_func_q == FUNC_INSERT) ? ST_P_RD : ST_DONE;
						end else begin
							state_d = ST_P_RD;
						end
					end
					JOB_PLACE: begin
						fl_we = 1'b1;
						if (!fv) begin
							fl_wdata = {1'b1, ft, fs};
							dt_we    = 1'b1;
							state_d  = ST_DONE;
						end else begin
							fl_wdata = {fv, ft, 1'b1};
							state_d  = last_probe ? ST_DONE : ST_P_RD;
						end
					end
					JOB_MOVE: begin
						fl_we = 1'b1;
						if (!fv) begin
							fl_wdata = {1'b1, ft, fs};
							dt_we    = 1'b1;
							if (rb_last_src) begin
								state_d = grow_q ? ST_MOD_GO : ST_DONE;
							end else begin
								state_d = ST_RB_RD;
							end
						end else begin
							fl_wdata = {fv, ft, 1'b1};
							state_d  = last_probe ? ST_DONE : ST_P_RD;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_DONE: begin
				if (out_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Slot memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (fl_we) begin
			flag_mem[fl_waddr] <= fl_wdata;
		end
		if (dt_we) begin
			data_mem[fl_waddr] <= dt_wdata;
		end
		rd_flags_q <= flag_mem[rd_addr];
		rd_entry_q <= data_mem[rd_addr];
	end

	// Datapath and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q        <= JOB_FIND;
			grow_q       <= 1'b0;
			op_func_q    <= '0;
			op_rec_q     <= '0;
			op_len_q     <= '0;
			op_key_q     <= '0;
			mv_q         <= '0;
			pkey_q       <= '0;
			tstep_q      <= '0;
			tbank_q      <= 1'b0;
			idx_q        <= '0;
			f_q          <= '0;
			d_q          <= '0;
			s0_q         <= '0;
			h2_q         <= '0;
			pc_q         <= '0;
			rb_new_q     <= '0;
			rb_i_q       <= '0;
			clr_q        <= '0;
			bank_q       <= 1'b0;
			step_q       <= '0;
			count_q      <= '0;
			hyst_q       <= '0;
			hyst_sq_q    <= '0;
			mode_q       <= '0;
			res_status_q <= '0;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			hyst_sq_q <= HQ'(hyst_q * hyst_q);
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_func_q <= in_data.func;
						op_rec_q  <= rec_m;
						op_len_q  <= len_c;
					end
				end
				ST_HASH: begin
					if (!adler_busy) begin
						op_key_q <= adler_key;
						if (op_func_q == FUNC_INSERT && grow_need) begin
							if (grow_ok) begin
								rb_new_q <= step_q + 1'b1;
								grow_q   <= 1'b1;
								clr_q    <= '0;
							end else begin
								res_status_q <= STATUS_CAP;
								res_slot_q   <= '0;
							end
						end else begin
							pkey_q  <= adler_key;
							tstep_q <= step_q;
							tbank_q <= bank_q;
							job_q   <= JOB_FIND;
						end
					end
				end
				ST_RB_CLR: begin
					clr_q  <= clr_q + 1'b1;
					rb_i_q <= '0;
				end
				ST_RB_EV: begin
					if (fv) begin
						mv_q    <= rd_entry_q;
						pkey_q  <= rd_entry_q.hash;
						tstep_q <= rb_new_q;
						tbank_q <= !bank_q;
						job_q   <= JOB_MOVE;
					end else if (rb_last_src) begin
						// Rebuild done: swap banks, resume the insert after growth
						bank_q  <= !bank_q;
						step_q  <= rb_new_q;
						pkey_q  <= op_key_q;
						tstep_q <= rb_new_q;
						tbank_q <= !bank_q;
						job_q   <= JOB_FIND;
					end else begin
						rb_i_q <= rb_i_q + 1'b1;
					end
				end
				ST_MOD: begin
					if (!mod_busy) begin
						idx_q <= rem_a;
						s0_q  <= rem_a;
						h2_q  <= h2_new;
						f_q   <= f_init(dbl, h2_new);
						d_q   <= d_init(dbl, quad, h2_new);
						pc_q  <= '0;
					end
				end
				ST_P_EV: begin
					case (job_q)
						JOB_FIND: begin
							if (match) begin
								res_slot_q <= idx_q;
								if (op_func_q == FUNC_INSERT) begin
									res_status_q <= STATUS_PRESENT;
								end else if (op_func_q == FUNC_DELETE) begin
									res_status_q <= STATUS_DELETED;
									count_q      <= cnt_dec;
									if (shrink) begin
										if (hyst_q != '1) begin
											hyst_q <= hyst_q + 1'b1;
										end
										rb_new_q <= step_q - 1'b1;
										grow_q   <= 1'b0;
										clr_q    <= '0;
									end
								end else begin
									res_status_q <= STATUS_FOUND;
								end
							end else if (chain_end || last_probe) begin
								if (op_func_q == FUNC_INSERT) begin
									// Restart the chain to place the record
									job_q <= JOB_PLACE;
									idx_q <= s0_q;
									f_q   <= f_init(dbl, h2_q);
									d_q   <= d_init(dbl, quad, h2_q);
									pc_q  <= '0;
								end else begin
									res_status_q <= STATUS_NOTFOUND;
									res_slot_q   <= '0;
								end
							end else begin
								idx_q <= idx_nx;
								f_q   <= f_nx;
								d_q   <= d_nx;
								pc_q  <= pc_q + 1'b1;
							end
						end
						JOB_PLACE: begin
							if (!fv) begin
								count_q      <= count_q + 1'b1;
								res_status_q <= STATUS_INSERTED;
								res_slot_q   <= idx_q;
							end else if (last_probe) begin
								res_status_q <= STATUS_CAP;
								res_slot_q   <= '0;
							end else begin
								idx_q <= idx_nx;
								f_q   <= f_nx;
								d_q   <= d_nx;
								pc_q  <= pc_q + 1'b1;
							end
						end
						JOB_MOVE: begin
							if (!fv) begin
								if (rb_last_src) begin
									bank_q  <= !bank_q;
									step_q  <= rb_new_q;
									pkey_q  <= op_key_q;
									tstep_q <= rb_new_q;
									tbank_q <= !bank_q;
									job_q   <= JOB_FIND;
								end else begin
									rb_i_q <= rb_i_q + 1'b1;
								end
							end else if (last_probe) begin
								// Abandon the rebuild; a failed growth rejects the insert
								if (grow_q) begin
									res_status_q <= STATUS_CAP;
									res_slot_q   <= '0;
								end
							end else begin
								idx_q <= idx_nx;
								f_q   <= f_nx;
								d_q   <= d_nx;
								pc_q  <= pc_q + 1'b1;
							end
						end
						default: begin
							res_status_q <= STATUS_NOTFOUND;
						end
					endcase
				end
				ST_DONE: begin
					if (out_take) begin
						out_valid_q     <= 1'b1;
						out_q.status    <= res_status_q;
						out_q.slot      <= 10'(res_slot_q);
						out_q.key       <= op_key_q;
						out_q.occupied  <= 10'(count_q);
						out_q.size_step <= 3'(step_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

>>> sv/ohash_adler.sv
// Adler-32 of a short record, one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ohash_adler import ohash_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [REC_W-1:0] rec,
	input  wire logic [LEN_W-1:0] len,
	output logic                  busy,
	output logic [KEY_W-1:0]      key
);

	logic [REC_W-1:0] rec_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [15:0]      a_q;
	logic [15:0]      b_q;
	logic             busy_q;
	logic [7:0]       byte_v;
	logic [PRIME_W-1:0] a_sum;
	logic [PRIME_W-1:0] a_nx;
	logic [PRIME_W-1:0] b_sum;
	logic [PRIME_W-1:0] b_nx;

	// Fold the current byte into both sums
	always_comb begin
		byte_v = rec_q[{cnt_q[2:0], 3'b000} +: 8];
		a_sum  = {1'b0, a_q} + {9'd0, byte_v};
		a_nx   = (a_sum >= ADLER_MOD) ? a_sum - ADLER_MOD : a_sum;
		b_sum  = {1'b0, b_q} + a_nx;
		b_nx   = (b_sum >= ADLER_MOD) ? b_sum - ADLER_MOD : b_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q  <= '0;
			len_q  <= '0;
			cnt_q  <= '0;
			a_q    <= 16'd1;
			b_q    <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			rec_q  <= rec;
			len_q  <= len;
			cnt_q  <= '0;
			a_q    <= 16'd1;
			b_q    <= '0;
			busy_q <= (len != '0);
		end else if (busy_q) begin
			a_q   <= a_nx[15:0];
			b_q   <= b_nx[15:0];
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q + 1'b1 == len_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign key  = {b_q, a_q};

endmodule
`default_nettype wire

>>> sv/ohash_mod.sv
// Bit-serial remainder of a key by two moduli at once, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ohash_mod import ohash_pkg::*; #(
	parameter int W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] dividend,
	input  wire logic [W-1:0]     mod_a,
	input  wire logic [W-1:0]     mod_b,
	output logic                  busy,
	output logic [W-1:0]          rem_a,
	output logic [W-1:0]          rem_b
);

	localparam int CW = $clog2(KEY_W);

	logic [KEY_W-1:0] dvd_q;
	logic [W-1:0]     ma_q;
	logic [W-1:0]     mb_q;
	logic [W-1:0]     ra_q;
	logic [W-1:0]     rb_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [W:0]       ta;
	logic [W:0]       tb;
	logic [W:0]       na;
	logic [W:0]       nb;

	// Shift in the next dividend bit and subtract once
	always_comb begin
		ta = {ra_q, dvd_q[KEY_W-1]};
		tb = {rb_q, dvd_q[KEY_W-1]};
		na = (ta >= {1'b0, ma_q}) ? ta - {1'b0, ma_q} : ta;
		nb = (tb >= {1'b0, mb_q}) ? tb - {1'b0, mb_q} : tb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
			ra_q   <= '0;
			rb_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			dvd_q  <= dividend;
			ma_q   <= mod_a;
			mb_q   <= mod_b;
			ra_q   <= '0;
			rb_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			ra_q  <= na[W-1:0];
			rb_q  <= nb[W-1:0];
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(KEY_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy  = busy_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule
`default_nettype wire

>>> sv/ohash_chk.sv
// Port checker for the hash table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ohash_chk import ohash_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_data
);

	// Hold a stalled response
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// Work one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// Report slot zero on a miss or a capacity failure
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_NOTFOUND || out_data.status == STATUS_CAP)
		|-> out_data.slot == '0)
		else $error("nonzero slot on a miss");

	// Report a nonempty table after an insert
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_INSERTED |-> out_data.occupied != '0)
		else $error("empty table after insert");

	// Use only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= STATUS_CAP)
		else $error("undefined status code");

endmodule

bind open_addressing_hash_table ohash_chk u_ohash_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
`default_nettype wire
